// File: hw/rtl/lsd_pkg.sv
// Shared widths, register indexes, reset values and the error counter saturation function.
package lsd_pkg;

    localparam int LINES_W    = 10;
    localparam int SAMPLES_W  = 12;
    localparam int LINE_NUM_W = 9;
    localparam int SAMPLE_W   = 16;
    localparam int SLOT_W     = 11;
    localparam int PTR_W      = 12;
    localparam int ERR_W      = 13;
    localparam int SUM_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE       = 2'd2;

    localparam logic [LINES_W-1:0]   LINES_RESET   = 10'd262;
    localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 12'd735;

    function automatic err_t sat_err(input sum_t v);
        err_t r;
        if (v[SUM_W-1] != v[SUM_W-2])
        begin
            r = v[SUM_W-1] ? err_t'({1'b1, {(ERR_W-1){1'b0}}})
                           : err_t'({1'b0, {(ERR_W-1){1'b1}}});
        end
        else
        begin
            r = err_t'(v[ERR_W-1:0]);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/line_to_sample_distributor.sv
// Line tick to audio sample slot distributor with a Bresenham error counter.
// Sequence: a stretch line counts its slots in ST_LOOP, up to the run cut at MAX_SLOTS_PER_LINE,
// settles the error counter in ST_FINISH and then loads its slots in ST_EMIT; a shrink line loads
// at most one slot, going from ST_START through ST_FINISH to ST_EMIT, or on line zero straight to ST_EMIT.
// Throughput: one line transaction at a time; the input stalls until the last slot is loaded,
// or until ST_FINISH finds the run empty, and it also stalls while the output is stalled.
// Reset: line count 262, sample count 735, error counter and slot pointer zero, no slot pending.
module line_to_sample_distributor #(
    parameter int MAX_SLOTS_PER_LINE = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lsd_pkg::LINE_NUM_W-1:0]        line_number,
    input  logic                                  dac_enable,
    input  logic signed [lsd_pkg::SAMPLE_W-1:0]   dac_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lsd_pkg::SLOT_W-1:0]            slot_index,
    output logic signed [lsd_pkg::SAMPLE_W-1:0]   sample_value,
    output logic                                  write_strobe,
    output logic                                  last_of_run,
    output logic                                  run_overflow
);

    localparam int CW = $clog2(MAX_SLOTS_PER_LINE + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SLOTS_PER_LINE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOP,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t                                 state_reg, state_next;
    logic [lsd_pkg::LINES_W-1:0]            lines_reg, lines_next;
    logic [lsd_pkg::SAMPLES_W-1:0]          samples_reg, samples_next;
    logic [lsd_pkg::LINE_NUM_W-1:0]         line_reg, line_next;
    logic                                   en_reg, en_next;
    logic signed [lsd_pkg::SAMPLE_W-1:0]    val_reg, val_next;
    lsd_pkg::err_t                          ec_reg, ec_next;
    logic [lsd_pkg::PTR_W-1:0]              ptr_reg, ptr_next;
    logic [lsd_pkg::PTR_W-1:0]              start_reg, start_next;
    logic [CW-1:0]                          n_reg, n_next;
    logic [CW-1:0]                          k_reg, k_next;
    logic                                   ovf_reg, ovf_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [lsd_pkg::SLOT_W-1:0]             slot_reg, slot_next;
    logic signed [lsd_pkg::SAMPLE_W-1:0]    sample_reg, sample_next;
    logic                                   strobe_reg, strobe_next;
    logic                                   last_reg, last_next;
    logic                                   flag_reg, flag_next;

    lsd_pkg::sum_t                          add_a;
    lsd_pkg::sum_t                          add_b;
    lsd_pkg::sum_t                          add_sum;
    lsd_pkg::err_t                          add_sat;
    lsd_pkg::sum_t                          l_ext;
    lsd_pkg::sum_t                          s_ext;
    lsd_pkg::sum_t                          ec_ext;
    logic                                   shrink;
    logic                                   line_zero;
    logic                                   last_line;
    logic                                   out_free;

    assign l_ext     = lsd_pkg::sum_t'({4'b0000, lines_reg});
    assign s_ext     = lsd_pkg::sum_t'({2'b00, samples_reg});
    assign ec_ext    = lsd_pkg::sum_t'({ec_reg[lsd_pkg::ERR_W-1], ec_reg});
    assign shrink    = samples_reg <= {2'b00, lines_reg};
    assign line_zero = line_reg == '0;
    assign last_line = (lines_reg != '0)
                    && ({1'b0, line_reg} == (lines_reg - lsd_pkg::LINES_W'(1)));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        add_a = ec_ext;
        add_b = -l_ext;
        unique case (state_reg)
            ST_START:
            begin
                if (shrink && line_zero)
                begin
                    add_a = l_ext;
                    add_b = -s_ext;
                end
                else if (shrink)
                begin
                    add_b = l_ext;
                end
                else
                begin
                    add_a = '0;
                    add_b = s_ext;
                end
            end
            ST_FINISH:
            begin
                add_b = shrink ? -s_ext : s_ext;
            end
            default:
            begin
                add_b = -l_ext;
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign add_sat = lsd_pkg::sat_err(add_sum);

    always_comb
    begin
        state_next     = state_reg;
        lines_next     = lines_reg;
        samples_next   = samples_reg;
        line_next      = line_reg;
        en_next        = en_reg;
        val_next       = val_reg;
        ec_next        = ec_reg;
        ptr_next       = ptr_reg;
        start_next     = start_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        slot_next      = slot_reg;
        sample_next    = sample_reg;
        strobe_next    = strobe_reg;
        last_next      = last_reg;
        flag_next      = flag_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                lsd_pkg::CFG_LINES_PER_FRAME:   lines_next   = cfg_data[lsd_pkg::LINES_W-1:0];
                lsd_pkg::CFG_SAMPLES_PER_FRAME: samples_next = cfg_data;
                // Stereo pairing is applied by the consumer; slot numbering is the same.
                lsd_pkg::CFG_STEREO_MODE:       ;
                default:                        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    line_next  = line_number;
                    en_next    = dac_enable;
                    val_next   = dac_value;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                k_next   = '0;
                ovf_next = 1'b0;
                n_next   = '0;
                if (shrink && line_zero)
                begin
                    ec_next    = add_sat;
                    start_next = '0;
                    ptr_next   = lsd_pkg::PTR_W'(1);
                    n_next     = CW'(1);
                    state_next = ST_EMIT;
                end
                else if (shrink)
                begin
                    start_next = ptr_reg;
                    if (ec_reg[lsd_pkg::ERR_W-1])
                    begin
                        ec_next  = add_sat;
                        ptr_next = ptr_reg + lsd_pkg::PTR_W'(1);
                        n_next   = CW'(1);
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (line_zero)
                    begin
                        ec_next    = add_sat;
                        ptr_next   = '0;
                        start_next = '0;
                    end
                    else
                    begin
                        start_next = ptr_reg;
                    end
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (last_line ? (ptr_reg < samples_reg) : !ec_reg[lsd_pkg::ERR_W-1])
                begin
                    if (n_reg == MAX_COUNT)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        if (!last_line)
                        begin
                            ec_next = add_sat;
                        end
                        ptr_next = ptr_reg + lsd_pkg::PTR_W'(1);
                        n_next   = n_reg + CW'(1);
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                ec_next    = add_sat;
                state_next = (n_reg == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = start_reg[lsd_pkg::SLOT_W-1:0];
                    sample_next    = val_reg;
                    strobe_next    = en_reg && (start_reg < samples_reg);
                    last_next      = k_reg == (n_reg - CW'(1));
                    flag_next      = ovf_reg;
                    start_next     = start_reg + lsd_pkg::PTR_W'(1);
                    k_next         = k_reg + CW'(1);
                    if (k_reg == (n_reg - CW'(1)))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lines_reg     <= lsd_pkg::LINES_RESET;
            samples_reg   <= lsd_pkg::SAMPLES_RESET;
            ec_reg        <= '0;
            ptr_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lines_reg     <= lines_next;
            samples_reg   <= samples_next;
            ec_reg        <= ec_next;
            ptr_reg       <= ptr_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg   <= line_next;
        en_reg     <= en_next;
        val_reg    <= val_next;
        start_reg  <= start_next;
        slot_reg   <= slot_next;
        sample_reg <= sample_next;
        strobe_reg <= strobe_next;
        last_reg   <= last_next;
        flag_reg   <= flag_next;
    end

    assign in_stall     = state_reg != ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign slot_index   = slot_reg;
    assign sample_value = sample_reg;
    assign write_strobe = strobe_reg;
    assign last_of_run  = last_reg;
    assign run_overflow = flag_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_START)
        else $error("accepted transaction did not start the sequencer");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_COUNT)
        else $error("slot run exceeds the maximum length");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> n_reg != '0 && k_reg < n_reg)
        else $error("emit with no slot left in the run");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && ovf_reg |-> n_reg == MAX_COUNT)
        else $error("overflow flagged on a run that was not cut");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && out_free && k_reg == (n_reg - CW'(1)) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after the final slot");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the line to sample distributor: directed table and random frames.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_SLOTS     = 16;
    localparam int ERR_MAX       = (1 << (lsd_pkg::ERR_W - 1)) - 1;
    localparam int ERR_MIN       = -(1 << (lsd_pkg::ERR_W - 1));
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 250;
    localparam int RANDOM_ITEMS  = 80;
    localparam int FINAL_ITEMS   = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 1000000;

    localparam int EXTREME_LINES [4] = '{0, 1, 512, 1023};
    localparam int EXTREME_SAMPLES [4] = '{0, 1, 2048, 4095};

    typedef struct {
        logic [lsd_pkg::SLOT_W-1:0]          slot;
        logic signed [lsd_pkg::SAMPLE_W-1:0] value;
        logic                                strobe;
        logic                                last;
        logic                                ovf;
    } slot_t;

    typedef enum logic {ROW_CONFIG, ROW_LINE} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        arg0;
        int        arg1;
        int        arg2;
        bit        typed;
        int        n;
        int        first;
        bit        strobe;
        bit        ovf;
    } stim_row_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_write;
    logic [lsd_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [lsd_pkg::CFG_DATA_W-1:0]        cfg_data;
    logic                                  in_valid;
    logic                                  in_stall;
    logic [lsd_pkg::LINE_NUM_W-1:0]        line_number;
    logic                                  dac_enable;
    logic signed [lsd_pkg::SAMPLE_W-1:0]   dac_value;
    logic                                  out_valid;
    logic                                  out_stall;
    logic [lsd_pkg::SLOT_W-1:0]            slot_index;
    logic signed [lsd_pkg::SAMPLE_W-1:0]   sample_value;
    logic                                  write_strobe;
    logic                                  last_of_run;
    logic                                  run_overflow;

    int                        lines_cfg;
    int                        samples_cfg;
    bit                        stereo_cfg;
    int                        err_acc;
    logic [lsd_pkg::PTR_W-1:0] slot_ptr;

    slot_t     run_slots[$];
    slot_t     expected_slots[$];
    stim_row_t stim_rows[$];

    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;
    bit hold_req = 1'b0;

    int mismatches    = 0;
    int items_sent    = 0;
    int slots_seen    = 0;
    int cut_runs      = 0;
    int configs_done  = 0;
    int stereo_phases = 0;

    line_to_sample_distributor #(
        .MAX_SLOTS_PER_LINE(MAX_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .line_number  (line_number),
        .dac_enable   (dac_enable),
        .dac_value    (dac_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot_index   (slot_index),
        .sample_value (sample_value),
        .write_strobe (write_strobe),
        .last_of_run  (last_of_run),
        .run_overflow (run_overflow)
    );

    always #1 clk = ~clk;

    function automatic int clamp_err(int v);
        if (v > ERR_MAX)
            return ERR_MAX;
        if (v < ERR_MIN)
            return ERR_MIN;
        return v;
    endfunction

    function automatic void emit_slot(logic en, logic signed [lsd_pkg::SAMPLE_W-1:0] val);
        slot_t s;
        s.slot   = slot_ptr[lsd_pkg::SLOT_W-1:0];
        s.value  = val;
        s.strobe = en && (int'(slot_ptr) < samples_cfg);
        s.last   = 1'b0;
        s.ovf    = 1'b0;
        run_slots.push_back(s);
        slot_ptr = slot_ptr + lsd_pkg::PTR_W'(1);
    endfunction

    function automatic void predict_line(int line, logic en,
                                         logic signed [lsd_pkg::SAMPLE_W-1:0] val);
        int lpf;
        int spf;
        bit cut;
        lpf = lines_cfg;
        spf = samples_cfg;
        cut = 1'b0;
        run_slots.delete();
        if (spf <= lpf)
        begin
            if (line == 0)
            begin
                err_acc  = clamp_err(lpf - spf);
                slot_ptr = '0;
                emit_slot(en, val);
            end
            else
            begin
                if (err_acc < 0)
                begin
                    emit_slot(en, val);
                    err_acc = clamp_err(err_acc + lpf);
                end
                err_acc = clamp_err(err_acc - spf);
            end
        end
        else
        begin
            if (line == 0)
            begin
                err_acc  = clamp_err(spf);
                slot_ptr = '0;
            end
            if (lpf >= 1 && line == lpf - 1)
            begin
                while (int'(slot_ptr) < spf && !cut)
                begin
                    if (run_slots.size() >= MAX_SLOTS)
                        cut = 1'b1;
                    else
                        emit_slot(en, val);
                end
            end
            else
            begin
                while (err_acc >= 0 && !cut)
                begin
                    if (run_slots.size() >= MAX_SLOTS)
                        cut = 1'b1;
                    else
                    begin
                        err_acc = clamp_err(err_acc - lpf);
                        emit_slot(en, val);
                    end
                end
            end
            err_acc = clamp_err(err_acc + spf);
        end
        foreach (run_slots[k])
            run_slots[k].ovf = cut;
        if (run_slots.size() > 0)
            run_slots[run_slots.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_row(row_kind_t kind, int a0, int a1, int a2,
                                    bit typed, int n, int first, bit strobe, bit ovf);
        stim_row_t r;
        r.kind   = kind;
        r.arg0   = a0;
        r.arg1   = a1;
        r.arg2   = a2;
        r.typed  = typed;
        r.n      = n;
        r.first  = first;
        r.strobe = strobe;
        r.ovf    = ovf;
        stim_rows.push_back(r);
    endfunction

    task automatic set_config(int lpf, int spf, int stereo);
        in_valid <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= lsd_pkg::CFG_LINES_PER_FRAME;
        cfg_data  <= lsd_pkg::CFG_DATA_W'(lpf);
        @(posedge clk);
        cfg_index <= lsd_pkg::CFG_SAMPLES_PER_FRAME;
        cfg_data  <= lsd_pkg::CFG_DATA_W'(spf);
        @(posedge clk);
        cfg_index <= lsd_pkg::CFG_STEREO_MODE;
        cfg_data  <= lsd_pkg::CFG_DATA_W'(stereo);
        @(posedge clk);
        cfg_write   <= 1'b0;
        lines_cfg   = lpf % (1 << lsd_pkg::LINES_W);
        samples_cfg = spf % (1 << lsd_pkg::SAMPLES_W);
        stereo_cfg  = stereo[0];
        configs_done++;
        if (stereo_cfg)
            stereo_phases++;
    endtask

    task automatic send_line(int line, logic en, logic signed [lsd_pkg::SAMPLE_W-1:0] val,
                             bit typed, int n, int first, bit strobe, bit ovf);
        slot_t s;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        line_number <= line[lsd_pkg::LINE_NUM_W-1:0];
        dac_enable  <= en;
        dac_value   <= val;
        do
            @(posedge clk);
        while (in_stall);
        predict_line(line, en, val);
        if (typed)
        begin
            run_slots.delete();
            for (int k = 0; k < n; k++)
            begin
                s.slot   = lsd_pkg::SLOT_W'(first + k);
                s.value  = val;
                s.strobe = strobe;
                s.last   = (k == n - 1);
                s.ovf    = ovf;
                run_slots.push_back(s);
            end
        end
        foreach (run_slots[k])
            expected_slots.push_back(run_slots[k]);
        items_sent++;
    endtask

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("tb_top: mismatch: %s", msg);
    endfunction

    always @(posedge clk)
    begin
        slot_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            slots_seen++;
            if (last_of_run && run_overflow)
                cut_runs++;
            if (expected_slots.size() == 0)
            begin
                note_mismatch($sformatf("slot transaction with none expected: slot %0d value %0d",
                                        slot_index, sample_value));
            end
            else
            begin
                want = expected_slots.pop_front();
                if (slot_index !== want.slot || sample_value !== want.value ||
                    write_strobe !== want.strobe || last_of_run !== want.last ||
                    run_overflow !== want.ovf)
                begin
                    note_mismatch($sformatf(
                        "slot expected %0d %0d %0b %0b %0b, got %0d %0d %0b %0b %0b",
                        want.slot, want.value, want.strobe, want.last, want.ovf,
                        slot_index, sample_value, write_strobe, last_of_run, run_overflow));
                end
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int lpf;
        int spf;
        int line;
        int len;
        int random_items;
        int waited;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        line_number = '0;
        dac_enable  = 1'b0;
        dac_value   = '0;
        lines_cfg   = int'(lsd_pkg::LINES_RESET);
        samples_cfg = int'(lsd_pkg::SAMPLES_RESET);
        stereo_cfg  = 1'b0;
        err_acc     = 0;
        slot_ptr    = '0;
        random_items = 0;

        add_row(ROW_LINE,   0,    1, 'h7FFF, 1, 3,  0,  1, 0);
        add_row(ROW_LINE,   1,    0, 'h8000, 0, 0,  0,  0, 0);
        add_row(ROW_LINE,   261,  1, 'h0000, 1, 16, 6,  1, 1);
        add_row(ROW_CONFIG, 512,  1, 1,      0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    1, 'h0001, 1, 1,  0,  1, 0);
        add_row(ROW_LINE,   511,  1, 'hFFFF, 1, 0,  0,  0, 0);
        add_row(ROW_LINE,   1,    1, 'h5555, 0, 0,  0,  0, 0);
        add_row(ROW_CONFIG, 1,    2048, 0,   0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    1, 'hAAAA, 1, 16, 0,  1, 1);
        add_row(ROW_LINE,   0,    0, 'h1234, 1, 16, 0,  0, 1);
        add_row(ROW_LINE,   5,    1, 'h8001, 1, 16, 16, 1, 1);
        add_row(ROW_CONFIG, 0,    100, 0,    0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    1, 'h0F0F, 1, 16, 0,  1, 1);
        add_row(ROW_LINE,   511,  1, 'hF0F0, 0, 0,  0,  0, 0);
        add_row(ROW_CONFIG, 1023, 4095, 1,   0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    1, 'h7FFE, 0, 0,  0,  0, 0);
        add_row(ROW_LINE,   511,  0, 'h8000, 0, 0,  0,  0, 0);
        add_row(ROW_CONFIG, 100,  100, 1,    0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    0, 'h0000, 1, 1,  0,  0, 0);
        add_row(ROW_LINE,   1,    1, 'h3C3C, 0, 0,  0,  0, 0);
        add_row(ROW_LINE,   2,    1, 'hC3C3, 0, 0,  0,  0, 0);
        add_row(ROW_CONFIG, 5,    0, 0,      0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    1, 'h7FFF, 1, 1,  0,  0, 0);
        add_row(ROW_LINE,   3,    1, 'h0100, 0, 0,  0,  0, 0);
        add_row(ROW_CONFIG, 4,    10, 0,     0, 0,  0,  0, 0);
        add_row(ROW_LINE,   0,    1, 'h1111, 0, 0,  0,  0, 0);
        add_row(ROW_LINE,   1,    1, 'h2222, 0, 0,  0,  0, 0);
        add_row(ROW_LINE,   2,    0, 'h3333, 0, 0,  0,  0, 0);
        add_row(ROW_LINE,   3,    1, 'hCCCC, 0, 0,  0,  0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CONFIG)
                set_config(stim_rows[i].arg0, stim_rows[i].arg1, stim_rows[i].arg2);
            else
                send_line(stim_rows[i].arg0, stim_rows[i].arg1[0],
                          lsd_pkg::SAMPLE_W'(stim_rows[i].arg2),
                          stim_rows[i].typed, stim_rows[i].n, stim_rows[i].first,
                          stim_rows[i].strobe, stim_rows[i].ovf);
        end

        for (int phase = 0; random_items < RANDOM_ITEMS; phase++)
        begin
            if (phase == 1)
            begin
                lpf = 3;
                spf = 200;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lpf = $urandom_range(2, 16);
                        spf = $urandom_range(1, lpf);
                    end
                    1:
                    begin
                        lpf = $urandom_range(1, 12);
                        spf = $urandom_range(lpf + 1, lpf * 6);
                    end
                    2:
                    begin
                        lpf = EXTREME_LINES[$urandom_range(0, 3)];
                        spf = EXTREME_SAMPLES[$urandom_range(0, 3)];
                    end
                    default:
                    begin
                        lpf = $urandom_range(0, 1023);
                        spf = $urandom_range(0, 4095);
                    end
                endcase
            end
            set_config(lpf, spf, $urandom_range(0, 1));
            if (phase == 1)
            begin
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            len  = $urandom_range(12, 28);
            line = -1;
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    line = $urandom_range(0, 511);
                end
                else if (lpf > 24 && lpf <= 513 && line >= 0 && $urandom_range(0, 7) == 0)
                begin
                    line = lpf - 2;
                end
                else
                begin
                    line = line + 1;
                    if (line >= lpf || line > 511)
                        line = 0;
                end
                send_line(line, $urandom_range(0, 3) != 0, lsd_pkg::SAMPLE_W'($urandom),
                          1'b0, 0, 0, 1'b0, 1'b0);
                random_items++;
            end
            idle_on = 1'b1;
        end

        // The closing stretch runs back to back, and almost every line is cut at the maximum run.
        idle_on  = 1'b0;
        stall_on = 1'b0;
        set_config(1, 4095, 1);
        for (int k = 0; k < FINAL_ITEMS; k++)
            send_line($urandom_range(1, 511), $urandom_range(0, 3) != 0,
                      lsd_pkg::SAMPLE_W'($urandom), 1'b0, 0, 0, 1'b0, 1'b0);
        in_valid <= 1'b0;

        waited = 0;
        while (expected_slots.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);

        $display("tb_top: %0d line transactions, %0d slot transactions, %0d cut runs",
                 items_sent, slots_seen, cut_runs);
        $display("tb_top: %0d register settings (%0d stereo), a long output hold, a closing %s",
                 configs_done, stereo_phases, "back-to-back stretch");
        if (mismatches == 0 && expected_slots.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
